// ----- sv/pol_pkg.sv -----
// shared types and codes for the positional ordered list
`timescale 1ns / 1ps

package pol_pkg;

    // default number of cells in the chain
    localparam int CAPACITY_DEF = 32;

    // fixed field widths
    localparam int WORD_W   = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // action codes carried by an input beat
    typedef enum logic [2:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_INS_AT    = 3'd2,
        ACT_DEL_FRONT = 3'd3,
        ACT_DEL_BACK  = 3'd4,
        ACT_DEL_AT    = 3'd5,
        ACT_DUMP      = 3'd6
    } action_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    // per-cycle operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

endpackage

// ----- sv/pol_cell.sv -----
// one storage cell of the shifting list chain
`timescale 1ns / 1ps

module pol_cell #(
    parameter int CW  = 6,
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  pol_pkg::cell_op_t                  op,
    input  logic [CW-1:0]                      pos,
    input  logic signed [pol_pkg::WORD_W-1:0]  bus,
    input  logic signed [pol_pkg::WORD_W-1:0]  left_data,
    input  logic signed [pol_pkg::WORD_W-1:0]  right_data,
    output logic signed [pol_pkg::WORD_W-1:0]  data
);
    import pol_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    // pick the new word from self, a neighbor or the broadcast bus
    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_INS:
            begin
                if (IDX_C == pos)
                    data_next = bus;
                else if (IDX_C > pos)
                    data_next = left_data;
            end
            CELL_DEL:
            begin
                if (IDX_C >= pos)
                    data_next = right_data;
            end
            CELL_ROT:
            begin
                if (IDX_C < pos)
                    data_next = right_data;
                else if (IDX_C == pos)
                    data_next = bus;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // word storage, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- sv/pol_chain.sv -----
// row of list cells wired to their neighbors
`timescale 1ns / 1ps

module pol_chain #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                               clk,
    input  pol_pkg::cell_op_t                  op,
    input  logic [CW-1:0]                      pos,
    input  logic signed [pol_pkg::WORD_W-1:0]  bus,
    output logic signed [pol_pkg::WORD_W-1:0]  front
);
    import pol_pkg::*;

    logic signed [WORD_W-1:0] cell_data [CAPACITY];

    // cell i sees cell i-1 on the left, cell i+1 on the right; zero and itself at the ends
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        pol_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .pos        (pos),
            .bus        (bus),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i])
        );
    end

    assign front = cell_data[0];

endmodule

// ----- sv/positional_ordered_list_top.sv -----
// positional ordered list: control, status and result register over a cell chain
`timescale 1ns / 1ps
//
// Bounded ordered list of signed 32-bit words held in a shifting row of cells.
// Input channel: in_valid / in_stall with action, value, position. Output
// channel: out_valid / out_stall with status, count, element, last.
// Inserts and deletes at any position are applied in parallel: every cell picks
// its left or right neighbor, the inserted word or itself at once. Their
// single result beat appears on the cycle after the beat is taken, and a new
// input beat can be taken every cycle while results drain.
// A dump of n elements sends n beats, one per cycle while the receiver does
// not stall, front first, with last on the final one; the chain rotates one
// place per beat so the front cell always holds the next word, and after n
// beats the order is restored. The dump sequencer loads each beat into the
// result register, and the input stays stalled until the final beat is loaded.
// A dump of an empty list gives one beat with status empty.
// Reset clears the count, the dump sequencer and the output valid; cell
// contents are left as they are. When the receiver stalls, the result beat
// holds and the input is stalled until the result register frees up.
//
module positional_ordered_list_top #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           action,
    input  logic signed [pol_pkg::WORD_W-1:0]    value,
    input  logic [pol_pkg::POS_W-1:0]            position,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pol_pkg::STATUS_W-1:0]         status,
    output logic [pol_pkg::COUNT_W-1:0]          count,
    output logic signed [pol_pkg::WORD_W-1:0]    element,
    output logic                                 last
);
    import pol_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        dump_idx_reg, dump_idx_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg;
    logic [CW-1:0]        rcount_reg;
    logic signed [WORD_W-1:0] element_reg;
    logic                 last_reg;

    logic                 out_free;
    logic                 accept;
    logic                 res_load;
    status_t              res_status;
    logic signed [WORD_W-1:0] res_element;
    logic                 res_last;

    cell_op_t             cell_op;
    logic [CW-1:0]        cell_pos;
    logic signed [WORD_W-1:0] cell_bus;
    logic signed [WORD_W-1:0] front;

    logic [CMPW-1:0]      posx;
    logic [CMPW-1:0]      cntx;
    logic [CMPW-1:0]      pos_m1;
    logic                 dump_last;

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    assign posx      = CMPW'(position);
    assign cntx      = CMPW'(count_reg);
    assign pos_m1    = posx - 1'b1;
    assign dump_last = (dump_idx_reg == CW'(count_reg - 1'b1));

    // action decode and sequencing
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        res_load      = 1'b0;
        res_status    = STAT_OK;
        res_element   = '0;
        res_last      = 1'b1;
        cell_op       = CELL_HOLD;
        cell_pos      = '0;
        cell_bus      = value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    case (action_t'(action))
                        ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
                        begin
                            if ((action_t'(action) == ACT_INS_AT) &&
                                ((position == '0) || (pos_m1 > cntx)))
                                res_status = STAT_BADPOS;
                            else if (count_reg == CAP_C)
                                res_status = STAT_FULL;
                            else
                            begin
                                cell_op = CELL_INS;
                                if (action_t'(action) == ACT_INS_FRONT)
                                    cell_pos = '0;
                                else if (action_t'(action) == ACT_INS_BACK)
                                    cell_pos = count_reg;
                                else
                                    cell_pos = CW'(pos_m1);
                                count_next = CW'(count_reg + 1'b1);
                            end
                        end
                        ACT_DEL_FRONT, ACT_DEL_BACK:
                        begin
                            if (count_reg == '0)
                                res_status = STAT_EMPTY;
                            else
                            begin
                                cell_op    = CELL_DEL;
                                cell_pos   = (action_t'(action) == ACT_DEL_FRONT) ?
                                             '0 : CW'(count_reg - 1'b1);
                                count_next = CW'(count_reg - 1'b1);
                            end
                        end
                        ACT_DEL_AT:
                        begin
                            if ((position == '0) || (pos_m1 >= cntx))
                                res_status = STAT_BADPOS;
                            else
                            begin
                                cell_op    = CELL_DEL;
                                cell_pos   = CW'(pos_m1);
                                count_next = CW'(count_reg - 1'b1);
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (count_reg == '0)
                                res_status = STAT_EMPTY;
                            else
                            begin
                                res_load      = 1'b0;
                                dump_idx_next = '0;
                                state_next    = S_DUMP;
                            end
                        end
                        default:
                        begin
                            res_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // emit the front word and rotate it to the back
                if (out_free)
                begin
                    res_load      = 1'b1;
                    res_element   = front;
                    res_last      = dump_last;
                    cell_op       = CELL_ROT;
                    cell_pos      = CW'(count_reg - 1'b1);
                    cell_bus      = front;
                    dump_idx_next = CW'(dump_idx_reg + 1'b1);
                    if (dump_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid follows loads and drains on an unstalled beat
    always_comb
    begin
        if (res_load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg  <= res_status;
            rcount_reg  <= count_next;
            element_reg <= res_element;
            last_reg    <= res_last;
        end
    end

    // cell row
    pol_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain (
        .clk   (clk),
        .op    (cell_op),
        .pos   (cell_pos),
        .bus   (cell_bus),
        .front (front)
    );

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = COUNT_W'(rcount_reg);
    assign element   = element_reg;
    assign last      = last_reg;

endmodule

// ----- verif/positional_ordered_list_checker.sv -----
// result checker for the positional ordered list: shadow list, expected beats, field compare
`timescale 1ns / 1ps

module positional_ordered_list_checker #(
    parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [2:0]                          action,
    input  logic signed [pol_pkg::WORD_W-1:0]   value,
    input  logic [pol_pkg::POS_W-1:0]           position,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [pol_pkg::STATUS_W-1:0]        status,
    input  logic [pol_pkg::COUNT_W-1:0]         count,
    input  logic signed [pol_pkg::WORD_W-1:0]   element,
    input  logic                                last,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  beats_seen,
    output int                                  list_size,
    output int                                  peak_size
);
    import pol_pkg::*;

    // one result beat as the list should produce it
    typedef struct packed {
        status_t                    st;
        logic [COUNT_W-1:0]         cnt;
        logic signed [WORD_W-1:0]   elem;
        logic                       lst;
    } list_beat_t;

    // shadow copy of the list, front at cell 0
    logic signed [WORD_W-1:0]   shadow_cells [CAPACITY];
    logic [COUNT_W-1:0]         held;
    list_beat_t                 expected_beats [$];

    // open a slot at a 0-based index and place a word there
    function automatic status_t insert_word(input int slot,
                                            input logic signed [WORD_W-1:0] word);
        if (slot > int'(held))
            return STAT_BADPOS;
        if (int'(held) >= CAPACITY)
            return STAT_FULL;
        for (int i = int'(held); i > slot; i--)
            shadow_cells[i] = shadow_cells[i-1];
        shadow_cells[slot] = word;
        held = held + 1'b1;
        return STAT_OK;
    endfunction

    // close the gap left by the word at a 0-based index
    function automatic status_t remove_word(input int slot);
        if (slot >= int'(held))
            return STAT_BADPOS;
        for (int i = slot; i < int'(held) - 1; i++)
            shadow_cells[i] = shadow_cells[i+1];
        held = held - 1'b1;
        return STAT_OK;
    endfunction

    // update the shadow list for one input beat and queue the beats it causes
    task automatic predict_beats(input logic [2:0] act,
                                 input logic signed [WORD_W-1:0] word,
                                 input logic [POS_W-1:0] pos);
        status_t st;
        st = STAT_OK;
        case (act)
            ACT_INS_FRONT: st = insert_word(0, word);
            ACT_INS_BACK:  st = insert_word(int'(held), word);
            ACT_INS_AT:    st = (pos == 0) ? STAT_BADPOS : insert_word(int'(pos) - 1, word);
            ACT_DEL_FRONT: st = (held == 0) ? STAT_EMPTY : remove_word(0);
            ACT_DEL_BACK:  st = (held == 0) ? STAT_EMPTY : remove_word(int'(held) - 1);
            ACT_DEL_AT:    st = (pos == 0) ? STAT_BADPOS : remove_word(int'(pos) - 1);
            ACT_DUMP:
            begin
                if (held == 0)
                    st = STAT_EMPTY;
                else
                begin
                    // every element front to back, last flag on the final one
                    for (int k = 0; k < int'(held); k++)
                        expected_beats.push_back('{STAT_OK, held, shadow_cells[k],
                                                   k == int'(held) - 1});
                    return;
                end
            end
            default: st = STAT_OK;
        endcase
        expected_beats.push_back('{st, held, '0, 1'b1});
    endtask

    // compare output beats against the oldest expectation, then predict input beats
    always @(posedge clk)
    begin : watch_channels
        list_beat_t want;
        if (!rst_n)
        begin
            held = '0;
            expected_beats.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_seen++;
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected beat: status %0d count %0d element %0d last %0b",
                           status, count, element, last);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        mismatches++;
                    end
                    if (count !== want.cnt)
                    begin
                        $error("count: expected %0d, got %0d", want.cnt, count);
                        mismatches++;
                    end
                    if (element !== want.elem)
                    begin
                        $error("element: expected %0d, got %0d", $signed(want.elem), element);
                        mismatches++;
                    end
                    if (last !== want.lst)
                    begin
                        $error("last: expected %0b, got %0b", want.lst, last);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_beats(action, value, position);
        end
        pending   = expected_beats.size();
        list_size = int'(held);
        if (int'(held) > peak_size)
            peak_size = int'(held);
    end

endmodule

// ----- verif/positional_ordered_list_top_tb.sv -----
// testbench top for the positional ordered list: clock, reset, beat stimulus and verdict
`timescale 1ns / 1ps

module positional_ordered_list_top_tb;
    import pol_pkg::*;

    localparam int         CAPACITY    = CAPACITY_DEF;
    localparam logic [2:0] ACT_SPARE   = 3'd7;          // code with no action assigned
    localparam int         TAIL_CYCLES = 2 * CAPACITY + 16;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         LONG_HOLD   = 64;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [2:0]                 action;
    logic signed [WORD_W-1:0]   value;
    logic [POS_W-1:0]           position;
    logic                       out_valid;
    logic                       out_stall;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         count;
    logic signed [WORD_W-1:0]   element;
    logic                       last;

    int mismatches;
    int pending;
    int beats_seen;
    int list_size;
    int peak_size;
    int items_sent = 0;
    int cycles     = 0;
    bit calm       = 1'b0;

    positional_ordered_list_top #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .count     (count),
        .element   (element),
        .last      (last)
    );

    positional_ordered_list_checker #(
        .CAPACITY (CAPACITY)
    ) list_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .count      (count),
        .element    (element),
        .last       (last),
        .mismatches (mismatches),
        .pending    (pending),
        .beats_seen (beats_seen),
        .list_size  (list_size),
        .peak_size  (peak_size)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("positional_ordered_list_top_tb failed");
            $finish;
        end
    end

    // result side: random stall per beat, two long holds to back the block up
    initial
    begin : result_sink
        int hold;
        int beats_taken;
        beats_taken = 0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (beats_taken == 12 || beats_taken == 150)
                hold = LONG_HOLD;
            else
                hold = calm ? 0 : $urandom_range(0, 7);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            beats_taken++;
        end
    end

    // random gap before a beat; returns at the falling edge where the beat is driven
    task automatic idle_gap();
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
    endtask

    // put one beat on the input and hold it until taken
    task automatic drive_beat(input logic [2:0] act,
                              input logic signed [WORD_W-1:0] word,
                              input logic [POS_W-1:0] pos);
        in_valid <= 1'b1;
        action   <= act;
        value    <= word;
        position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic offer(input logic [2:0] act,
                         input logic signed [WORD_W-1:0] word,
                         input logic [POS_W-1:0] pos);
        idle_gap();
        drive_beat(act, word, pos);
    endtask

    // random beat; grow_pct sets the share of inserts, positions mostly in range
    task automatic offer_random(input int grow_pct);
        int size;
        int roll;
        logic [2:0] act;
        logic [POS_W-1:0] pos;
        logic signed [WORD_W-1:0] word;
        idle_gap();
        size = list_size;
        roll = $urandom_range(0, 99);
        word = $urandom;
        if ($urandom_range(0, 9) == 0)
            word = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        pos = POS_W'($urandom_range(0, 63));
        if (roll < grow_pct)
        begin
            act = 3'($urandom_range(ACT_INS_FRONT, ACT_INS_AT));
            if (act == ACT_INS_AT && $urandom_range(0, 7) != 0)
                pos = POS_W'($urandom_range(1, size + 1));
        end
        else if (roll < 93)
        begin
            act = 3'($urandom_range(ACT_DEL_FRONT, ACT_DEL_AT));
            if (act == ACT_DEL_AT && size > 0 && $urandom_range(0, 7) != 0)
                pos = POS_W'($urandom_range(1, size));
        end
        else if (roll < 98)
            act = ACT_DUMP;
        else
            act = ACT_SPARE;
        drive_beat(act, word, pos);
    endtask

    // stop offering until every expected result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // reset, directed corners, random phases, verdict
    initial
    begin : stimulus
        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = ACT_INS_FRONT;
        value    = '0;
        position = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // empty list corners
        offer(ACT_DUMP,      32'sd0, 6'd0);
        offer(ACT_DEL_FRONT, 32'sd0, 6'd0);
        offer(ACT_DEL_BACK,  32'sd0, 6'd0);
        offer(ACT_DEL_AT,    32'sd0, 6'd1);
        offer(ACT_INS_AT,    32'sd5, 6'd0);
        offer(ACT_INS_AT,    32'sd5, 6'd2);

        // build a short list with extreme words
        offer(ACT_INS_AT,    32'sh8000_0000, 6'd1);
        offer(ACT_INS_FRONT, 32'sh7fff_ffff, 6'd0);
        offer(ACT_INS_BACK,  -32'sd1,        6'd0);
        offer(ACT_INS_AT,    32'sd0,         6'd4);
        offer(ACT_INS_AT,    32'sh5a5a_a5a5, 6'd63);
        offer(ACT_INS_AT,    32'sh2aaa_5555, 6'd3);
        offer(ACT_DUMP,      32'sd0,         6'd63);

        // bad delete positions, then take it apart
        offer(ACT_DEL_AT,    32'sd0, 6'd0);
        offer(ACT_DEL_AT,    32'sd0, 6'd63);
        offer(ACT_DEL_AT,    32'sd0, 6'd6);
        offer(ACT_DEL_AT,    32'sd0, 6'd2);
        offer(ACT_DEL_FRONT, 32'sd0, 6'd0);
        offer(ACT_DEL_BACK,  32'sd0, 6'd0);
        offer(ACT_SPARE,     32'sh1234_5678, 6'd21);
        offer(ACT_DUMP,      32'sd0, 6'd0);
        offer(ACT_DEL_AT,    32'sd0, 6'd1);
        offer(ACT_DEL_BACK,  32'sd0, 6'd0);
        drain_results();

        // fill to capacity and beyond, then dump the full list
        repeat (45) offer_random(95);
        offer(ACT_DUMP, $urandom, POS_W'($urandom_range(0, 63)));
        drain_results();

        // only deletes, dumps and spare codes, running into the empty list
        repeat (30) offer_random(0);
        drain_results();

        // no idling on either side
        calm = 1'b1;
        repeat (10) offer_random(55);
        offer(ACT_DUMP, $urandom, POS_W'($urandom_range(0, 63)));
        calm = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d input beats and %0d result beats, list peaked at %0d of %0d cells",
                 items_sent, beats_seen, peak_size, CAPACITY);
        if (mismatches == 0)
            $display("positional_ordered_list_top_tb passed");
        else
            $display("positional_ordered_list_top_tb failed");
        $finish;
    end

endmodule
